// File: rtl/eemi_pkg.sv
// Package for the extended Euclid modular inverse block.
// Holds the default operand width; no dependencies.
package eemi_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

endpackage

// File: rtl/extended_euclid_mod_inverse_top.sv
// Extended Euclid modular inverse: top level.
// Depends on eemi_pkg for the default operand width.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a modulus and a
//   value. Output channel (out_valid/out_ready) returns the gcd, the raw
//   signed Bezout coefficient of the value, the flag invertible (gcd is 1)
//   and the coefficient reduced into 0..modulus-1 (zero when not invertible).
//   One request is worked on at a time; in_ready is high only when idle.
//   Each Euclid step runs on one shared restoring divider, one quotient bit
//   a cycle, which also accumulates quotient times coefficient by shift-add.
//   The final reduction reuses the divider. Reset (rst_n low, synchronous)
//   returns the sequencer to idle and drops any pending result. While the
//   receiver stalls the result is held in the output registers; one further
//   request is taken and worked, then waits in its final state until the
//   output registers are free.
module extended_euclid_mod_inverse_top #(
  parameter int unsigned DATA_WIDTH = eemi_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [DATA_WIDTH-1:0]        in_modulus,
  input  logic [DATA_WIDTH-1:0]        in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DATA_WIDTH-1:0]        out_gcd_result,
  output logic signed [DATA_WIDTH:0]   out_coef_value,
  output logic [DATA_WIDTH-1:0]        out_inverse,
  output logic                         out_invertible
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_RED,
    ST_RDIV,
    ST_FIX,
    ST_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, m_r, m_nxt;
  logic [W-1:0]  prev_r, prev_nxt, cur_r, cur_nxt, acc_r, acc_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [W-1:0]  inv_r, inv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          par_r, par_nxt, stepped_r, stepped_nxt, ok_r, ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_gcd_r, out_gcd_nxt, out_inv_r, out_inv_nxt;
  logic [W:0]    out_coef_r, out_coef_nxt;
  logic          out_ok_r, out_ok_nxt;

  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          qbit;
  logic [W-1:0]  rem_step, dvd_step, acc_step, next_mag;
  logic          neg;
  logic [W:0]    coef;

  assign shifted  = {rem_r, dvd_r[W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit     = ~diff[W+1];
  assign rem_step = qbit ? diff[W-1:0] : shifted[W-1:0];
  assign dvd_step = {dvd_r[W-2:0], qbit};
  assign acc_step = {acc_r[W-2:0], 1'b0} + (qbit ? cur_r : {W{1'b0}});
  assign next_mag = prev_r + acc_r;
  assign neg      = stepped_r && !par_r && (prev_r != {W{1'b0}});
  assign coef     = neg ? ({(W+1){1'b0}} - {1'b0, prev_r}) : {1'b0, prev_r};

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    inv_nxt       = inv_r;
    cnt_nxt       = cnt_r;
    par_nxt       = par_r;
    stepped_nxt   = stepped_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_gcd_nxt   = out_gcd_r;
    out_inv_nxt   = out_inv_r;
    out_coef_nxt  = out_coef_r;
    out_ok_nxt    = out_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt       = in_modulus;
          b_nxt       = in_value;
          m_nxt       = in_modulus;
          prev_nxt    = {W{1'b0}};
          cur_nxt     = {{(W-1){1'b0}}, 1'b1};
          par_nxt     = 1'b0;
          stepped_nxt = 1'b0;
          dvd_nxt     = in_modulus;
          dvs_nxt     = in_value;
          rem_nxt     = {W{1'b0}};
          acc_nxt     = {W{1'b0}};
          cnt_nxt     = CNT_LAST;
          state_nxt   = (in_value == {W{1'b0}}) ? ST_RED : ST_DIV;
        end
      end
      ST_DIV, ST_RDIV: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        acc_nxt = acc_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == {CW{1'b0}}) begin
          state_nxt = (state_r == ST_DIV) ? ST_UPD : ST_FIX;
        end
      end
      ST_UPD: begin
        a_nxt       = b_r;
        b_nxt       = rem_r;
        prev_nxt    = cur_r;
        cur_nxt     = next_mag;
        par_nxt     = !par_r;
        stepped_nxt = 1'b1;
        dvd_nxt     = b_r;
        dvs_nxt     = rem_r;
        rem_nxt     = {W{1'b0}};
        acc_nxt     = {W{1'b0}};
        cnt_nxt     = CNT_LAST;
        state_nxt   = (rem_r == {W{1'b0}}) ? ST_RED : ST_DIV;
      end
      ST_RED: begin
        ok_nxt  = (a_r == {{(W-1){1'b0}}, 1'b1});
        inv_nxt = {W{1'b0}};
        if (a_r != {{(W-1){1'b0}}, 1'b1}) begin
          state_nxt = ST_FIN;
        end else if (m_r == {W{1'b0}}) begin
          inv_nxt   = prev_r;
          state_nxt = ST_FIN;
        end else begin
          dvd_nxt   = prev_r;
          dvs_nxt   = m_r;
          rem_nxt   = {W{1'b0}};
          acc_nxt   = {W{1'b0}};
          cnt_nxt   = CNT_LAST;
          state_nxt = ST_RDIV;
        end
      end
      ST_FIX: begin
        inv_nxt   = (neg && rem_r != {W{1'b0}}) ? (m_r - rem_r) : rem_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_gcd_nxt   = a_r;
          out_coef_nxt  = coef;
          out_inv_nxt   = inv_r;
          out_ok_nxt    = ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    m_r        <= m_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    inv_r      <= inv_nxt;
    cnt_r      <= cnt_nxt;
    par_r      <= par_nxt;
    stepped_r  <= stepped_nxt;
    ok_r       <= ok_nxt;
    out_gcd_r  <= out_gcd_nxt;
    out_coef_r <= out_coef_nxt;
    out_inv_r  <= out_inv_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_gcd_result = out_gcd_r;
  assign out_coef_value = out_coef_r;
  assign out_inverse    = out_inv_r;
  assign out_invertible = out_ok_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_RDIV) |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

  a_div_runs_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != {CW{1'b0}}) |=> (state_r == ST_DIV))
    else $error("divide left before last quotient bit");

  a_inv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && ok_r && m_r != {W{1'b0}}) |-> (inv_r < m_r))
    else $error("reduced inverse not below modulus");

  a_flag_matches_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_gcd_r == {{(W-1){1'b0}}, 1'b1})))
    else $error("invertible flag disagrees with gcd");

  a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_inv_r == {W{1'b0}}))
    else $error("inverse non-zero without invertible");

endmodule

// File: tb/tb.sv
// Testbench for extended_euclid_mod_inverse_top: directed and random modulus/value
// requests, with a behavioural Euclid predictor checking each result field.
// Depends on eemi_pkg and the top level RTL.
module tb;

  localparam int unsigned DW = eemi_pkg::DATA_WIDTH_DEF;
  localparam int unsigned AW = 2 * DW + 2;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_AT = 60;
  localparam int unsigned HOLD_LEN = 2500;
  localparam int unsigned BURST_LO = 150;
  localparam int unsigned BURST_HI = 210;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned SETTLE_CYCLES = 1700;

  typedef struct packed {
    logic [DW-1:0] modulus;
    logic [DW-1:0] value;
  } request_t;

  typedef struct {
    logic [DW-1:0]      gcd_result;
    logic signed [DW:0] coef_value;
    logic [DW-1:0]      inverse;
    logic               invertible;
  } inverse_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DW-1:0]       in_modulus = '0;
  logic [DW-1:0]       in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DW-1:0]       out_gcd_result;
  logic signed [DW:0]  out_coef_value;
  logic [DW-1:0]       out_inverse;
  logic                out_invertible;

  request_t            request_q[$];
  inverse_result_t     pending_inverses[$];
  request_t            next_req;
  inverse_result_t     want;
  int unsigned         in_count = 0;
  int unsigned         out_count = 0;
  int unsigned         error_count = 0;
  int unsigned         stall_cycles = 0;
  int unsigned         hold_left = 0;
  logic                hold_done = 1'b0;
  logic                in_burst;
  logic                out_burst;

  extended_euclid_mod_inverse_top #(.DATA_WIDTH(DW)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_modulus     (in_modulus),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_gcd_result (out_gcd_result),
    .out_coef_value (out_coef_value),
    .out_inverse    (out_inverse),
    .out_invertible (out_invertible)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic inverse_result_t euclid_inverse(input logic [DW-1:0] modulus,
                                                     input logic [DW-1:0] value);
    bit [AW-1:0]     m, a, b, q, r, prev, cur, nxt, red, signed_mag;
    int unsigned     steps;
    bit              neg;
    inverse_result_t res;
    m = AW'(modulus);
    a = m;
    b = AW'(value);
    prev = '0;
    cur = AW'(1);
    steps = 0;
    while (b != 0) begin
      q = a / b;
      r = a - q * b;
      nxt = prev + q * cur;
      a = b;
      b = r;
      prev = cur;
      cur = nxt;
      steps++;
    end
    neg = (steps != 0) && (steps % 2 == 0) && (prev != 0);
    signed_mag = neg ? (AW'(0) - prev) : prev;
    res.gcd_result = a[DW-1:0];
    res.coef_value = signed_mag[DW:0];
    res.invertible = (a == AW'(1));
    res.inverse = '0;
    if (res.invertible) begin
      if (m == 0) begin
        res.inverse = prev[DW-1:0];
      end else begin
        red = prev % m;
        red = (neg && red != 0) ? (m - red) : red;
        res.inverse = red[DW-1:0];
      end
    end
    return res;
  endfunction

  assign in_burst = (in_count >= BURST_LO) && (in_count < BURST_HI);
  assign out_burst = (out_count >= BURST_LO) && (out_count < BURST_HI);

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_inverses.push_back(euclid_inverse(in_modulus, in_value));
        in_count <= in_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && (in_burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_modulus <= next_req.modulus;
          in_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_count <= out_count + 1;
        if (pending_inverses.size() == 0) begin
          $display("%0t: unexpected result gcd %0h coef %0d inverse %0h invertible %0b",
                   $time, out_gcd_result, out_coef_value, out_inverse, out_invertible);
          error_count++;
        end else begin
          want = pending_inverses.pop_front();
          if (out_gcd_result !== want.gcd_result) begin
            $display("%0t: gcd_result expected %0h actual %0h",
                     $time, want.gcd_result, out_gcd_result);
            error_count++;
          end
          if (out_coef_value !== want.coef_value) begin
            $display("%0t: coef_value expected %0d actual %0d",
                     $time, want.coef_value, out_coef_value);
            error_count++;
          end
          if (out_inverse !== want.inverse) begin
            $display("%0t: inverse expected %0h actual %0h",
                     $time, want.inverse, out_inverse);
            error_count++;
          end
          if (out_invertible !== want.invertible) begin
            $display("%0t: invertible expected %0b actual %0b",
                     $time, want.invertible, out_invertible);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && out_count == HOLD_AT) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end else begin
        out_ready <= out_burst || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("extended_euclid_mod_inverse_top: mismatch");
    $finish;
  end

  function automatic request_t mk_req(input logic [DW-1:0] modulus,
                                      input logic [DW-1:0] value);
    request_t req;
    req.modulus = modulus;
    req.value = value;
    return req;
  endfunction

  function automatic logic [DW-1:0] edge_operand(input int unsigned pick);
    case (pick)
      0: return '0;
      1: return DW'(1);
      2: return DW'(2);
      3: return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  initial begin
    logic [DW-1:0] m, v, g, fa, fb, ft;
    int unsigned   k, sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    request_q.push_back(mk_req('0, '0));
    request_q.push_back(mk_req(DW'(5), '0));
    request_q.push_back(mk_req('0, DW'(1)));
    request_q.push_back(mk_req('0, DW'(5)));
    request_q.push_back(mk_req('0, '1));
    request_q.push_back(mk_req(DW'(1), '0));
    request_q.push_back(mk_req(DW'(1), DW'(7)));
    request_q.push_back(mk_req(DW'(1), '1));
    request_q.push_back(mk_req(DW'(2), DW'(1)));
    request_q.push_back(mk_req('1, '1));
    request_q.push_back(mk_req('1, DW'(1)));
    request_q.push_back(mk_req('1, '1 - DW'(1)));
    request_q.push_back(mk_req('1 - DW'(1), DW'(2)));
    request_q.push_back(mk_req(DW'(3120), DW'(17)));
    request_q.push_back(mk_req(DW'(17), DW'(3120)));
    request_q.push_back(mk_req(DW'(12), DW'(8)));
    request_q.push_back(mk_req(DW'(7), DW'(7)));
    request_q.push_back(mk_req(DW'(100), DW'(99)));
    request_q.push_back(mk_req(DW'(32'hFFFF_FFFB), DW'(3)));
    request_q.push_back(mk_req(DW'(32'hAAAA_AAAA), DW'(32'h5555_5555)));
    request_q.push_back(mk_req(DW'(32'h5555_5555), DW'(32'hAAAA_AAAA)));
    request_q.push_back(mk_req(DW'(32'd2971215073), DW'(32'd1836311903)));
    request_q.push_back(mk_req(DW'(32'd1836311903), DW'(32'd2971215073)));

    // hold the next requests back until every result has come
    while (request_q.size() != 0 || in_valid || pending_inverses.size() != 0) @(posedge clk);
    @(negedge clk);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: begin
          m = DW'($urandom);
          v = DW'($urandom);
        end
        4, 5: begin
          m = DW'($urandom_range(0, 65535));
          v = DW'($urandom_range(0, 65535));
        end
        6: begin
          g = DW'($urandom_range(2, 1000));
          m = g * DW'($urandom_range(1, 4000000));
          v = g * DW'($urandom_range(0, 4000000));
        end
        7: begin
          m = DW'($urandom) >> $urandom_range(0, 31);
          v = DW'($urandom) | DW'(32'h8000_0000);
        end
        8: begin
          m = edge_operand($urandom_range(0, 5));
          v = edge_operand($urandom_range(0, 5));
        end
        default: begin
          k = $urandom_range(2, 46);
          fa = DW'(1);
          fb = '0;
          repeat (k) begin
            ft = fa + fb;
            fb = fa;
            fa = ft;
          end
          if ($urandom_range(0, 1) == 0) begin
            m = fa;
            v = fb;
          end else begin
            m = fb;
            v = fa;
          end
        end
      endcase
      request_q.push_back(mk_req(m, v));
    end

    while (request_q.size() != 0 || in_valid || pending_inverses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_inverses.size() == 0) begin
      $display("extended_euclid_mod_inverse_top: match");
    end else begin
      $display("extended_euclid_mod_inverse_top: mismatch");
    end
    $finish;
  end

endmodule
